[sv/knn_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// knn_pkg
// Shared types and constants of the nearest-reference RSSI position estimator:
// the item structs of the request and result channels and the register codes.
// ---------------------------------------------------------------------------
package knn_pkg;

   // Field widths of the items.
   localparam int RSSI_W  = 12;
   localparam int COORD_W = 8;
   localparam int COUNT_W = 7;

   // Register port.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 12;

   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_RSSI = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_K_NEAREST   = 1'b1;

   // Register reset values.
   localparam logic [RSSI_W-1:0]  TARGET_RESET = '0;
   localparam logic [COUNT_W-1:0] K_RESET      = 7'd4;

   // One reference tag.
   typedef struct packed {
      logic signed [RSSI_W-1:0] ref_rssi;
      logic                     ref_seen;
      logic [COORD_W-1:0]       ref_x;
      logic [COORD_W-1:0]       ref_y;
      logic                     last_ref;
   } req_type;

   // One position estimate.
   typedef struct packed {
      logic [COORD_W-1:0] est_x;
      logic [COORD_W-1:0] est_y;
      logic [COUNT_W-1:0] used_count;
   } rsp_type;

endpackage
`default_nettype wire

[sv/knn_rssi_position_estimate_core.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// knn_rssi_position_estimate_core
// Nearest-reference position estimator. Each request item is one reference
// tag; the item that carries last_ref closes the set and yields one result
// item with the mean x and y (rounded down) of the k references whose RSSI
// lies closest to the target RSSI, and the number of references used.
//
// Usage:
//  - req_*: valid/ready. req_ready is high only while the sequencer is idle.
//  - rsp_*: valid/ready. The result sits in an output register; the block
//    goes on taking reference items while it waits. A second result stalls
//    in the sequencer until the first one has been taken.
//  - csr_*: register writes, always ready. Index 0 is target_rssi, index 1
//    is k_nearest. Write only while the block is idle.
// Sequence:
//  - An unseen reference leaves the list alone. A seen reference is inserted
//    into a sorted list held in one memory by compare and shift through its
//    single read and single write port: a read and a compare for each entry
//    moved, and at the head of the list a write with no compare.
//  - The closing item then sums the chosen entries, runs the restoring divider
//    shared by x and y (skipped when no reference was used) and loads the
//    result register.
// Reset: synchronous; clears the list fill count, the sequencer and the
// result valid, and sets target_rssi to 0 and k_nearest to 4. The list
// memory needs no clearing pass.
// ---------------------------------------------------------------------------
module knn_rssi_position_estimate_core #(
   parameter int MAX_NEAREST = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  knn_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output knn_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [knn_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [knn_pkg::CSR_DATA_W-1:0]    csr_data
);
   import knn_pkg::*;

   localparam int AW = (MAX_NEAREST > 1) ? $clog2(MAX_NEAREST) : 1;
   localparam int CW = $clog2(MAX_NEAREST + 1);
   localparam int KW = (CW > COUNT_W) ? CW : COUNT_W;
   localparam int SW = COORD_W + CW;
   localparam int BW = $clog2(COORD_W);

   typedef struct packed {
      logic [RSSI_W-1:0]  delta;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_RD,
      S_INS_CMP,
      S_SUM_START,
      S_SUM_RD,
      S_SUM_ACC,
      S_DIV,
      S_OUT
   } state_type;

   state_type           state_ff, state_in;
   entry_type           new_ff, new_in;
   logic                last_ff, last_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [CW-1:0]       fill_ff, fill_in;
   logic [CW-1:0]       used_ff, used_in;
   logic [CW-1:0]       j_ff, j_in;
   logic [SW-1:0]       sx_ff, sx_in;
   logic [SW-1:0]       sy_ff, sy_in;
   logic [BW-1:0]       bit_ff, bit_in;
   logic [COORD_W-1:0]  qx_ff, qx_in;
   logic [COORD_W-1:0]  qy_ff, qy_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;
   logic [RSSI_W-1:0]   target_ff, target_in;
   logic [COUNT_W-1:0]  k_ff, k_in;

   // Sorted list memory.
   entry_type           best_mem [MAX_NEAREST];
   entry_type           rd_q_ff;
   logic                mem_we;
   logic [AW-1:0]       mem_wa;
   entry_type           mem_wd;
   logic [AW-1:0]       mem_ra;

   logic [RSSI_W:0]     diff;
   logic [RSSI_W:0]     abs_diff;
   logic [CW-1:0]       ra_full;
   logic [KW-1:0]       k_eff;
   logic [KW-1:0]       fill_ext;
   logic [SW-1:0]       trial;

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Distance of the incoming reference to the target RSSI.
   assign diff     = {req_data.ref_rssi[RSSI_W-1], req_data.ref_rssi}
                   - {target_ff[RSSI_W-1], target_ff};
   assign abs_diff = diff[RSSI_W] ? (~diff + 1'b1) : diff;

   // Read address: the entry below the slot being filled, or the sum index.
   assign ra_full = idx_ff - CW'(1);
   assign mem_ra  = (state_ff == S_SUM_RD) ? j_ff[AW-1:0] : ra_full[AW-1:0];

   // Effective k: zero counts as one, large values saturate to the list depth.
   always_comb begin
      k_eff = KW'(k_ff);
      if (k_ff == '0) begin
         k_eff = KW'(1);
      end else if (KW'(k_ff) > KW'(MAX_NEAREST)) begin
         k_eff = KW'(MAX_NEAREST);
      end
   end
   assign fill_ext = KW'(fill_ff);

   // Divisor shifted to the quotient bit under test.
   assign trial = SW'(used_ff) << bit_ff;

   // Sequencer and datapath next state.
   always_comb begin
      state_in     = state_ff;
      new_in       = new_ff;
      last_in      = last_ff;
      idx_in       = idx_ff;
      fill_in      = fill_ff;
      used_in      = used_ff;
      j_in         = j_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      bit_in       = bit_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      target_in    = target_ff;
      k_in         = k_ff;
      mem_we       = 1'b0;
      mem_wa       = '0;
      mem_wd       = new_ff;

      // Register writes.
      if (csr_valid) begin
         unique case (csr_index)
            CSR_TARGET_RSSI: target_in = csr_data[RSSI_W-1:0];
            CSR_K_NEAREST:   k_in      = csr_data[COUNT_W-1:0];
            default:         ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               new_in  = '{delta: abs_diff[RSSI_W-1:0], x: req_data.ref_x, y: req_data.ref_y};
               last_in = req_data.last_ref;
               if (req_data.ref_seen) begin
                  // A full list first checks its worst entry.
                  if (fill_ff == CW'(MAX_NEAREST)) begin
                     idx_in = CW'(MAX_NEAREST);
                  end else begin
                     idx_in  = fill_ff;
                     fill_in = fill_ff + CW'(1);
                  end
                  state_in = S_INS_RD;
               end else if (req_data.last_ref) begin
                  state_in = S_SUM_START;
               end
            end
         end

         S_INS_RD: begin
            // At the head of the list the new item simply lands in slot zero.
            if (idx_ff == '0) begin
               mem_we   = 1'b1;
               mem_wa   = '0;
               mem_wd   = new_ff;
               state_in = last_ff ? S_SUM_START : S_IDLE;
            end else begin
               state_in = S_INS_CMP;
            end
         end

         S_INS_CMP: begin
            if (rd_q_ff.delta > new_ff.delta) begin
               // Move the larger entry up one slot; the worst one of a full
               // list is dropped.
               if (idx_ff != CW'(MAX_NEAREST)) begin
                  mem_we = 1'b1;
                  mem_wa = idx_ff[AW-1:0];
                  mem_wd = rd_q_ff;
               end
               idx_in   = idx_ff - CW'(1);
               state_in = S_INS_RD;
            end else begin
               // Equal or smaller entries stay ahead of the new item.
               if (idx_ff != CW'(MAX_NEAREST)) begin
                  mem_we = 1'b1;
                  mem_wa = idx_ff[AW-1:0];
                  mem_wd = new_ff;
               end
               state_in = last_ff ? S_SUM_START : S_IDLE;
            end
         end

         S_SUM_START: begin
            used_in  = (fill_ext < k_eff) ? fill_ff : k_eff[CW-1:0];
            fill_in  = '0;
            j_in     = '0;
            sx_in    = '0;
            sy_in    = '0;
            state_in = S_SUM_RD;
         end

         S_SUM_RD: begin
            if (j_ff == used_ff) begin
               bit_in   = BW'(COORD_W - 1);
               qx_in    = '0;
               qy_in    = '0;
               state_in = (used_ff == '0) ? S_OUT : S_DIV;
            end else begin
               state_in = S_SUM_ACC;
            end
         end

         S_SUM_ACC: begin
            sx_in    = sx_ff + SW'(rd_q_ff.x);
            sy_in    = sy_ff + SW'(rd_q_ff.y);
            j_in     = j_ff + CW'(1);
            state_in = S_SUM_RD;
         end

         S_DIV: begin
            // One restoring step per cycle for x and y; the quotient fits
            // in eight bits since every term is below 256.
            if (sx_ff >= trial) begin
               sx_in         = sx_ff - trial;
               qx_in[bit_ff] = 1'b1;
            end
            if (sy_ff >= trial) begin
               sy_in         = sy_ff - trial;
               qy_in[bit_ff] = 1'b1;
            end
            if (bit_ff == '0) begin
               state_in = S_OUT;
            end else begin
               bit_in = bit_ff - BW'(1);
            end
         end

         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in  = '{est_x: qx_ff, est_y: qy_ff, used_count: COUNT_W'(used_ff)};
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         target_ff    <= TARGET_RESET;
         k_ff         <= K_RESET;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         target_ff    <= target_in;
         k_ff         <= k_in;
      end
      new_ff      <= new_in;
      last_ff     <= last_in;
      idx_ff      <= idx_in;
      used_ff     <= used_in;
      j_ff        <= j_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      bit_ff      <= bit_in;
      qx_ff       <= qx_in;
      qy_ff       <= qy_in;
      rsp_data_ff <= rsp_data_in;
   end

   // List memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         best_mem[mem_wa] <= mem_wd;
      end
      rd_q_ff <= best_mem[mem_ra];
   end

   // The list never holds more entries than it has slots.
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(MAX_NEAREST))
      else $error("list fill count exceeds the list depth");

   // The divider only runs with a nonzero divisor.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (used_ff != '0))
      else $error("divider started with zero references");

   // A compare step always has an entry below the current slot.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INS_CMP) |-> (idx_ff != '0))
      else $error("insertion compare at slot zero");

   // An estimate from no references is zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.used_count == '0)
         |-> (rsp_data_ff.est_x == '0 && rsp_data_ff.est_y == '0))
      else $error("nonzero estimate without references");

endmodule
`default_nettype wire

[tb/sv/tb_knn_rssi_position_estimate_core.sv]
// ---------------------------------------------------------------------------
// tb_knn_rssi_position_estimate_core
// Self-checking bench for the nearest-reference position estimator. Sets of
// reference tag items are streamed in. A local model keeps its own sorted
// nearest list and predicts each position estimate, and every estimate that
// comes out is compared field by field. Register settings change between
// sets and in the middle of a set, and both channels stall at random.
// ---------------------------------------------------------------------------
module tb_knn_rssi_position_estimate_core;

   import knn_pkg::*;

   localparam int NEAREST_MAX    = 64;
   localparam int DIRECTED_ITEMS = 19;
   localparam int RANDOM_ITEMS   = 1350;
   localparam int SETTLE_CYCLES  = 300;
   localparam int LONG_HOLD      = 600;
   localparam int WATCHDOG_LIMIT = 4000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_TARGET_RSSI;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Stimulus side.
   req_type               ref_q[$];
   int                    req_gap = 0;
   logic                  idle_on = 1'b0;
   int                    hold_requests = 0;
   int                    holds_served = 0;
   int                    hold_left = 0;
   int                    stall_left = 0;
   int                    refs_queued = 0;
   logic signed [11:0]    gen_target = TARGET_RESET;

   // Local model of the estimator.
   logic [11:0]           near_dist[NEAREST_MAX];
   logic [7:0]            near_x[NEAREST_MAX];
   logic [7:0]            near_y[NEAREST_MAX];
   int                    near_fill = 0;
   logic signed [11:0]    target_shadow = TARGET_RESET;
   logic [6:0]            k_shadow = K_RESET;
   rsp_type               estimate_q[$];

   // Bookkeeping.
   int                    refs_accepted = 0;
   int                    sets_closed = 0;
   int                    estimates_checked = 0;
   int                    csr_writes = 0;
   int                    full_list_hits = 0;
   int                    error_count = 0;
   int                    quiet_cycles = 0;

   knn_rssi_position_estimate_core #(
      .MAX_NEAREST(NEAREST_MAX)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data (csr_data)
   );

   // Clock generation.
   initial begin
      forever #5 clock = ~clock;
   end

   // Prints one mismatch line and counts it.
   task automatic report_error(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      error_count++;
   endtask

   // Adds one accepted reference to the local nearest list and, on the closing
   // item, predicts the estimate and clears the list.
   function automatic void take_reference(input req_type r);
      int      diff;
      int      pos;
      int      tail;
      int      k;
      int      used;
      int      sum_x;
      int      sum_y;
      rsp_type est;
      if (r.ref_seen) begin
         diff = int'($signed(r.ref_rssi)) - int'(target_shadow);
         if (diff < 0)
            diff = -diff;
         pos = 0;
         while (pos < near_fill && near_dist[pos] <= diff[11:0])
            pos++;
         if (near_fill == NEAREST_MAX)
            full_list_hits++;
         // Equal distances keep arrival order; a full list only takes a
         // strictly better reference and drops its worst entry.
         if (pos < NEAREST_MAX) begin
            if (near_fill < NEAREST_MAX) begin
               tail = near_fill;
               near_fill++;
            end else begin
               tail = NEAREST_MAX - 1;
            end
            for (int i = tail; i > pos; i--) begin
               near_dist[i] = near_dist[i-1];
               near_x[i]    = near_x[i-1];
               near_y[i]    = near_y[i-1];
            end
            near_dist[pos] = diff[11:0];
            near_x[pos]    = r.ref_x;
            near_y[pos]    = r.ref_y;
         end
      end
      if (r.last_ref) begin
         // A k of zero acts as one; a k above the list depth saturates.
         k = int'(k_shadow);
         if (k == 0)
            k = 1;
         if (k > NEAREST_MAX)
            k = NEAREST_MAX;
         used  = (near_fill < k) ? near_fill : k;
         sum_x = 0;
         sum_y = 0;
         for (int i = 0; i < used; i++) begin
            sum_x += near_x[i];
            sum_y += near_y[i];
         end
         est.est_x      = (used != 0) ? 8'(sum_x / used) : 8'd0;
         est.est_y      = (used != 0) ? 8'(sum_y / used) : 8'd0;
         est.used_count = 7'(used);
         estimate_q.push_back(est);
         sets_closed++;
         near_fill = 0;
      end
   endfunction

   // Compares one received estimate with the oldest prediction.
   task automatic check_estimate(input rsp_type got);
      rsp_type want;
      if (estimate_q.size() == 0) begin
         report_error($sformatf("estimate with no prediction waiting: x=%0d y=%0d n=%0d",
                                got.est_x, got.est_y, got.used_count));
      end else begin
         want = estimate_q.pop_front();
         estimates_checked++;
         if (got.est_x != want.est_x)
            report_error($sformatf("est_x got %0d want %0d", got.est_x, want.est_x));
         if (got.est_y != want.est_y)
            report_error($sformatf("est_y got %0d want %0d", got.est_y, want.est_y));
         if (got.used_count != want.used_count)
            report_error($sformatf("used_count got %0d want %0d",
                                   got.used_count, want.used_count));
      end
   endtask

   // Request driver: offers queued reference items with random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   <= 0;
      end else if (!req_valid || req_ready) begin
         if (req_gap != 0) begin
            req_valid <= 1'b0;
            req_gap   <= req_gap - 1;
         end else if (ref_q.size() != 0) begin
            req_data  <= ref_q.pop_front();
            req_valid <= 1'b1;
            if (idle_on && $urandom_range(0, 4) == 0)
               req_gap <= $urandom_range(1, 9);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver: random stall bursts, plus a long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
         hold_left  <= 0;
      end else if (hold_requests != holds_served) begin
         holds_served <= holds_served + 1;
         hold_left    <= LONG_HOLD;
         rsp_ready    <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 8);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Monitor: checks results, feeds the model and tracks register writes.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            check_estimate(rsp_data);
         if (req_valid && req_ready) begin
            refs_accepted <= refs_accepted + 1;
            take_reference(req_data);
         end
         if (csr_valid && csr_ready) begin
            csr_writes <= csr_writes + 1;
            case (csr_index)
               CSR_TARGET_RSSI: target_shadow <= csr_data;
               CSR_K_NEAREST:   k_shadow      <= csr_data[6:0];
               default: ;
            endcase
         end
      end
   end

   // Watchdog: counts cycles without any accepted item.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("Timeout: no item accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("FAILED: results differ");
      $finish;
   end

   function automatic req_type make_ref(input int rssi, input bit seen, input int x,
                                        input int y, input bit tail_ref);
      req_type r;
      r.ref_rssi = 12'(rssi);
      r.ref_seen = seen;
      r.ref_x    = 8'(x);
      r.ref_y    = 8'(y);
      r.last_ref = tail_ref;
      return r;
   endfunction

   task automatic push_ref(input req_type r);
      ref_q.push_back(r);
      refs_queued++;
   endtask

   // Random RSSI: extremes, values clustered around the target, or anything.
   function automatic logic [11:0] pick_rssi();
      case ($urandom_range(0, 5))
         0:       return 12'h800;
         1:       return 12'h7FF;
         2, 3:    return 12'(gen_target + $urandom_range(0, 16) - 8);
         default: return 12'($urandom_range(0, 4095));
      endcase
   endfunction

   function automatic logic [7:0] pick_coord();
      case ($urandom_range(0, 7))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Queues n references; the last one closes the set when asked.
   task automatic queue_refs(input int n, input bit close_set);
      int  seen_pct;
      seen_pct = ($urandom_range(0, 19) == 0) ? 0 : 90;
      for (int i = 0; i < n; i++)
         push_ref(make_ref(pick_rssi(), $urandom_range(0, 99) < seen_pct, pick_coord(),
                           pick_coord(), close_set && (i == n - 1)));
   endtask

   // Writes the chosen registers back to back; call at a rising edge.
   task automatic write_regs(input bit wr_target, input logic [11:0] t, input bit wr_k,
                             input logic [6:0] k);
      if (wr_target) begin
         csr_index <= CSR_TARGET_RSSI;
         csr_data  <= t;
         csr_valid <= 1'b1;
         @(posedge clock);
         while (!csr_ready)
            @(posedge clock);
         gen_target = t;
      end
      if (wr_k) begin
         csr_index <= CSR_K_NEAREST;
         csr_data  <= {5'b0, k};
         csr_valid <= 1'b1;
         @(posedge clock);
         while (!csr_ready)
            @(posedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   // Waits until every queued item is taken and every estimate is back, then
   // lets any insertion still in flight finish.
   task automatic wait_drained();
      @(posedge clock);
      while (refs_accepted != refs_queued || estimate_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Main sequence.
   initial begin : stimulus
      int          phase;
      int          budget;
      int          n;
      int          n1;
      int          carry_len;
      logic        calm;
      logic [11:0] t;
      logic [6:0]  kv;

      repeat (11) @(posedge clock);
      reset   <= 1'b0;
      idle_on <= 1'b1;

      // Directed: an unseen closing item with nothing seen, then a set with
      // field extremes, equal distances and an unseen member.
      @(negedge clock);
      push_ref(make_ref(0, 1'b0, 255, 255, 1'b1));
      push_ref(make_ref(2047, 1'b1, 255, 255, 1'b0));
      push_ref(make_ref(-2048, 1'b1, 0, 0, 1'b0));
      push_ref(make_ref(0, 1'b1, 255, 0, 1'b0));
      push_ref(make_ref(0, 1'b1, 0, 255, 1'b0));
      push_ref(make_ref(-1, 1'b0, 128, 1, 1'b0));
      push_ref(make_ref(1, 1'b1, 17, 99, 1'b1));
      wait_drained();

      // Lowest target gives the widest distance; k of zero acts as one.
      write_regs(1'b1, 12'h800, 1'b1, 7'd0);
      @(negedge clock);
      push_ref(make_ref(2047, 1'b1, 1, 2, 1'b0));
      push_ref(make_ref(-2048, 1'b1, 200, 100, 1'b0));
      push_ref(make_ref(-2047, 1'b1, 3, 4, 1'b1));
      wait_drained();

      // Highest target and the largest k, which saturates at the list depth.
      write_regs(1'b1, 12'h7FF, 1'b1, 7'd127);
      @(negedge clock);
      push_ref(make_ref(-2048, 1'b1, 10, 20, 1'b0));
      push_ref(make_ref(2047, 1'b1, 30, 40, 1'b0));
      push_ref(make_ref(0, 1'b1, 250, 5, 1'b0));
      push_ref(make_ref(1000, 1'b1, 7, 254, 1'b1));

      // Registers changed in the middle of a set.
      @(negedge clock);
      push_ref(make_ref(2040, 1'b1, 11, 12, 1'b0));
      push_ref(make_ref(1365, 1'b1, 13, 14, 1'b0));
      push_ref(make_ref(-5, 1'b1, 15, 16, 1'b0));
      wait_drained();
      write_regs(1'b1, 12'h555, 1'b1, 7'd2);
      @(negedge clock);
      push_ref(make_ref(1360, 1'b1, 100, 200, 1'b0));
      push_ref(make_ref(1370, 1'b1, 101, 201, 1'b1));
      wait_drained();

      // Random phases, each ending with the sender paused until all
      // estimates are back.
      phase     = 0;
      carry_len = 0;
      while (refs_queued < DIRECTED_ITEMS + RANDOM_ITEMS) begin
         calm = (refs_queued > DIRECTED_ITEMS + RANDOM_ITEMS * 85 / 100);
         idle_on <= !calm && ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 4) != 0) begin
            case ($urandom_range(0, 5))
               0:       t = 12'h800;
               1:       t = 12'h7FF;
               2:       t = 12'h000;
               default: t = 12'($urandom_range(0, 4095));
            endcase
            case ($urandom_range(0, 7))
               0:       kv = 7'd0;
               1:       kv = 7'd64;
               2:       kv = 7'($urandom_range(65, 127));
               3:       kv = 7'($urandom_range(9, 63));
               default: kv = 7'($urandom_range(1, 8));
            endcase
            write_regs(1'($urandom_range(0, 1)), t, 1'($urandom_range(0, 1)), kv);
         end
         @(negedge clock);

         // Once: hold the result side off while single-item sets pile up.
         if (phase == 0) begin
            hold_requests <= hold_requests + 1;
            for (int i = 0; i < 24; i++)
               queue_refs(1, 1'b1);
         end

         if (carry_len != 0) begin
            queue_refs(carry_len, 1'b1);
            carry_len = 0;
         end

         budget = $urandom_range(40, 120);
         if (phase % 9 == 4) begin
            // More references than the nearest list has slots, which can overflow it.
            n = $urandom_range(66, 90);
            queue_refs(n, 1'b1);
            budget -= n;
         end
         while (budget > 0) begin
            case ($urandom_range(0, 9))
               7, 8:    n = $urandom_range(11, 40);
               9:       n = $urandom_range(41, 64);
               default: n = $urandom_range(1, 10);
            endcase
            queue_refs(n, 1'b1);
            budget -= n;
         end

         // Sometimes leave a set open so the next settings land inside it.
         if (!calm && $urandom_range(0, 3) == 0) begin
            n  = $urandom_range(2, 12);
            n1 = $urandom_range(1, n - 1);
            queue_refs(n1, 1'b0);
            carry_len = n - n1;
         end
         wait_drained();
         phase++;
      end

      if (carry_len != 0) begin
         @(negedge clock);
         queue_refs(carry_len, 1'b1);
         wait_drained();
      end

      $display("Covered %0d reference items in %0d sets over %0d phases; %0d estimates checked.",
               refs_accepted, sets_closed, phase, estimates_checked);
      $display("%0d register writes; %0d references arrived at a full nearest list.",
               csr_writes, full_list_hits);
      if (error_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
